// ----- rtl/core/ess_pkg.sv -----
// Shared types and constants for the emergency stop supervisor core.
package ess_pkg;

   // Field widths fixed by the word layout
   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned CfgAddrBits = 2;
   localparam int unsigned ReqDataBits = 16;
   localparam int unsigned RspDataBits = 24;
   localparam int unsigned MaskBits    = 16;

   // Configuration register indexes
   localparam logic [CfgAddrBits-1:0] REG_RESET_PULSE   = 2'd0;
   localparam logic [CfgAddrBits-1:0] REG_HB_TIMEOUT    = 2'd1;
   localparam logic [CfgAddrBits-1:0] REG_TRIGGER_HOLD  = 2'd2;
   localparam logic [CfgAddrBits-1:0] REG_REPORT_PERIOD = 2'd3;

   // Register values after reset
   localparam logic [CfgWidth-1:0] RESET_PULSE_DEF   = 16'd100;
   localparam logic [CfgWidth-1:0] HB_TIMEOUT_DEF    = 16'd500;
   localparam logic [CfgWidth-1:0] TRIGGER_HOLD_DEF  = 16'd1000;
   localparam logic [CfgWidth-1:0] REPORT_PERIOD_DEF = 16'd100;

   // ESI patterns that name a source
   localparam logic [3:0] ESI_PAT_BIT9 = 4'h7;
   localparam logic [3:0] ESI_PAT_BIT0 = 4'h3;
   localparam logic [3:0] ESI_PAT_BIT4 = 4'h1;
   localparam logic [3:0] ESI_PAT_BIT8 = 4'h0;

   // Source mask bit positions
   localparam int unsigned SRC_ESI_A   = 9;
   localparam int unsigned SRC_ESI_B   = 0;
   localparam int unsigned SRC_ESI_C   = 4;
   localparam int unsigned SRC_ESI_D   = 8;
   localparam int unsigned SRC_LOGIC   = 10;
   localparam int unsigned SRC_NXP     = 11;
   localparam int unsigned SRC_ST      = 12;
   localparam int unsigned SRC_TK1     = 13;
   localparam int unsigned SRC_TRIGGER = 14;
   localparam int unsigned SRC_TIMEOUT = 15;

   // Emergency state machine
   typedef enum logic [1:0] {
      EM_UNKNOWN     = 2'd0,
      EM_NORMAL      = 2'd1,
      EM_TRIGGERED   = 2'd2,
      EM_RECOVERABLE = 2'd3
   } em_state_type;

   // Reset pulse and trigger latch phases
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_COUNT = 2'd2,
      PH_END   = 2'd3
   } phase_type;

   // Report timer phases
   typedef enum logic [1:0] {
      RPT_START  = 2'd0,
      RPT_COUNT  = 2'd1,
      RPT_SEND   = 2'd2,
      RPT_UNUSED = 2'd3
   } report_phase_type;

endpackage

// ----- rtl/core/emergency_stop_supervisor_core.sv -----
// Emergency stop supervisor: one sampled millisecond tick in, one status word out.
// The response word to an accepted request word is registered and offered in the next cycle.
// Throughput: one word per cycle while responses drain; a response held by rsp_tready
// low stalls the request side, since the next request is taken only as it leaves.
// Reset (synchronous, active high) returns every timer, flag and state to its idle value
// and loads the configuration registers with their default periods.
module emergency_stop_supervisor_core
   import ess_pkg::*;
#(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request words: ack[0], logic[1], status_in[2], status_ack[3], esi_pins[7:4],
   // nxp_ok[8], st_ok[9], tk1_ok[10], reset_request[11], trigger_request[12],
   // heartbeat[13], zero pad[15:14]
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Response words: reset_pin[0], trigger_pin_n[1], status_copy_pin[2],
   // emergency_state[4:3], source_mask[20:5], error_mask[22:21], report_strobe[23]
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Configuration writes
   input  logic                   csr_we,
   input  logic [CfgAddrBits-1:0] csr_addr,
   input  logic [CfgWidth-1:0]    csr_wdata
);

   localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

   // Configuration registers
   logic [CfgWidth-1:0] reset_pulse_ff, hb_timeout_ff, trigger_hold_ff, report_period_ff;

   // Supervisor state
   em_state_type          em_state_ff, em_state_in;
   logic [MaskBits-1:0]   source_ff, source_in;
   logic [1:0]            error_in;
   logic                  timeout_ff, timeout_in;
   logic                  armed_ff, armed_in;
   logic [TIMER_BITS-1:0] mon_cnt_ff, mon_cnt_in;
   phase_type             pulse_ph_ff, pulse_ph_in;
   logic [TIMER_BITS-1:0] pulse_cnt_ff, pulse_cnt_in;
   logic                  pulse_lvl_ff, pulse_lvl_in;
   logic                  trig_lat_ff, trig_lat_in;
   phase_type             trig_ph_ff, trig_ph_in;
   logic [TIMER_BITS-1:0] trig_cnt_ff, trig_cnt_in;
   report_phase_type      rpt_ph_ff, rpt_ph_in;
   logic [TIMER_BITS-1:0] rpt_cnt_ff, rpt_cnt_in;
   logic                  strobe_in;

   // Response register
   logic                   rsp_valid_ff;
   logic [RspDataBits-1:0] rsp_data_ff, rsp_data_in;

   // Unpacked request fields
   logic       ack, logic_lvl, st_in, st_ack, nxp, st, tk1, rst_req, trig_req, beat;
   logic [3:0] esi;
   logic       recoverable;
   logic       accept;

   assign ack       = req_tdata[0];
   assign logic_lvl = req_tdata[1];
   assign st_in     = req_tdata[2];
   assign st_ack    = req_tdata[3];
   assign esi       = req_tdata[7:4];
   assign nxp       = req_tdata[8];
   assign st        = req_tdata[9];
   assign tk1       = req_tdata[10];
   assign rst_req   = req_tdata[11];
   assign trig_req  = req_tdata[12];
   assign beat      = req_tdata[13];

   // Handshake: the response register frees as it drains
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pulse_ff   <= RESET_PULSE_DEF;
         hb_timeout_ff    <= HB_TIMEOUT_DEF;
         trigger_hold_ff  <= TRIGGER_HOLD_DEF;
         report_period_ff <= REPORT_PERIOD_DEF;
      end else if (csr_we) begin
         case (csr_addr)
            REG_RESET_PULSE:   reset_pulse_ff   <= csr_wdata;
            REG_HB_TIMEOUT:    hb_timeout_ff    <= csr_wdata;
            REG_TRIGGER_HOLD:  trigger_hold_ff  <= csr_wdata;
            REG_REPORT_PERIOD: report_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One tick of supervisor logic
   always_comb begin
      logic [TIMER_BITS-1:0] pulse_inc, mon_inc, trig_inc, rpt_inc;
      pulse_inc = (pulse_cnt_ff == TimerMax) ? pulse_cnt_ff : pulse_cnt_ff + 1'b1;
      mon_inc   = (mon_cnt_ff == TimerMax) ? mon_cnt_ff : mon_cnt_ff + 1'b1;
      trig_inc  = (trig_cnt_ff == TimerMax) ? trig_cnt_ff : trig_cnt_ff + 1'b1;
      rpt_inc   = (rpt_cnt_ff == TimerMax) ? rpt_cnt_ff : rpt_cnt_ff + 1'b1;

      // Reset pulse sequencer; a new request restarts it
      pulse_ph_in  = pulse_ph_ff;
      pulse_cnt_in = pulse_cnt_ff;
      pulse_lvl_in = pulse_lvl_ff;
      case (pulse_ph_ff)
         PH_START: begin
            pulse_cnt_in = '0;
            pulse_lvl_in = 1'b1;
            pulse_ph_in  = PH_COUNT;
         end
         PH_COUNT: begin
            pulse_cnt_in = pulse_inc;
            if ({{CfgWidth{1'b0}}, pulse_inc} >= {{TIMER_BITS{1'b0}}, reset_pulse_ff})
               pulse_ph_in = PH_END;
         end
         PH_END: begin
            pulse_lvl_in = 1'b0;
            pulse_ph_in  = PH_IDLE;
         end
         default: ;
      endcase
      if (rst_req) pulse_ph_in = PH_START;

      // Heartbeat monitor; the flag only updates once a heartbeat has been seen
      armed_in   = armed_ff || beat;
      mon_cnt_in = beat ? '0 : (armed_ff ? mon_inc : mon_cnt_ff);
      timeout_in = timeout_ff;
      if (armed_in)
         timeout_in = {{CfgWidth{1'b0}}, mon_cnt_in} > {{TIMER_BITS{1'b0}}, hb_timeout_ff};

      // Host trigger latch and hold timer
      trig_lat_in = trig_lat_ff || trig_req;
      trig_cnt_in = trig_cnt_ff;
      case (trig_ph_ff)
         PH_START: begin
            trig_cnt_in = '0;
            trig_ph_in  = PH_COUNT;
         end
         PH_COUNT: begin
            trig_cnt_in = trig_inc;
            trig_ph_in  = PH_COUNT;
            if ({{CfgWidth{1'b0}}, trig_inc} >= {{TIMER_BITS{1'b0}}, trigger_hold_ff}) begin
               trig_lat_in = 1'b0;
               trig_ph_in  = PH_IDLE;
            end
         end
         default: trig_ph_in = PH_IDLE;
      endcase
      if (trig_ph_in == PH_IDLE && trig_lat_in) trig_ph_in = PH_START;

      // All recovery sources released
      recoverable = tk1 && nxp && st && esi[3];

      // Sticky source bits
      source_in = source_ff;
      case (esi)
         ESI_PAT_BIT9: source_in[SRC_ESI_A] = 1'b1;
         ESI_PAT_BIT0: source_in[SRC_ESI_B] = 1'b1;
         ESI_PAT_BIT4: source_in[SRC_ESI_C] = 1'b1;
         ESI_PAT_BIT8: source_in[SRC_ESI_D] = 1'b1;
         default: ;
      endcase
      if (!logic_lvl)  source_in[SRC_LOGIC]   = 1'b1;
      if (!nxp)        source_in[SRC_NXP]     = 1'b1;
      if (!st)         source_in[SRC_ST]      = 1'b1;
      if (!tk1)        source_in[SRC_TK1]     = 1'b1;
      if (trig_lat_in) source_in[SRC_TRIGGER] = 1'b1;
      if (timeout_in)  source_in[SRC_TIMEOUT] = 1'b1;

      // Emergency state machine; returning to normal clears the sources
      em_state_in = em_state_ff;
      case (em_state_ff)
         EM_UNKNOWN:   em_state_in = ack ? EM_NORMAL : EM_TRIGGERED;
         EM_NORMAL:    if (!ack) em_state_in = EM_TRIGGERED;
         EM_TRIGGERED: if (recoverable) em_state_in = EM_RECOVERABLE;
         default: begin
            if (ack) begin
               source_in   = '0;
               em_state_in = EM_NORMAL;
            end else if (!recoverable) begin
               em_state_in = EM_TRIGGERED;
            end
         end
      endcase

      // Pin mismatch errors
      error_in = {st_in != st_ack, logic_lvl != ack};

      // Periodic report timer
      strobe_in  = 1'b0;
      rpt_cnt_in = rpt_cnt_ff;
      rpt_ph_in  = rpt_ph_ff;
      case (rpt_ph_ff)
         RPT_COUNT: begin
            rpt_cnt_in = rpt_inc;
            if ({{CfgWidth{1'b0}}, rpt_inc} >= {{TIMER_BITS{1'b0}}, report_period_ff})
               rpt_ph_in = RPT_SEND;
         end
         RPT_SEND: begin
            strobe_in = 1'b1;
            rpt_ph_in = RPT_START;
         end
         default: begin
            rpt_cnt_in = '0;
            rpt_ph_in  = RPT_COUNT;
         end
      endcase

      // Response word
      rsp_data_in = {strobe_in, error_in, source_in, em_state_in, ack,
                     !(timeout_in || trig_lat_in), pulse_lvl_in};
   end

   // State and response registers advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         em_state_ff  <= EM_UNKNOWN;
         source_ff    <= '0;
         timeout_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         mon_cnt_ff   <= '0;
         pulse_ph_ff  <= PH_IDLE;
         pulse_cnt_ff <= '0;
         pulse_lvl_ff <= 1'b0;
         trig_lat_ff  <= 1'b0;
         trig_ph_ff   <= PH_IDLE;
         trig_cnt_ff  <= '0;
         rpt_ph_ff    <= RPT_START;
         rpt_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            em_state_ff  <= em_state_in;
            source_ff    <= source_in;
            timeout_ff   <= timeout_in;
            armed_ff     <= armed_in;
            mon_cnt_ff   <= mon_cnt_in;
            pulse_ph_ff  <= pulse_ph_in;
            pulse_cnt_ff <= pulse_cnt_in;
            pulse_lvl_ff <= pulse_lvl_in;
            trig_lat_ff  <= trig_lat_in;
            trig_ph_ff   <= trig_ph_in;
            trig_cnt_ff  <= trig_cnt_in;
            rpt_ph_ff    <= rpt_ph_in;
            rpt_cnt_ff   <= rpt_cnt_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   // A timeout can only be flagged once the monitor has been armed
   a_timeout_armed: assert property (@(posedge clock) disable iff (reset)
      timeout_ff |-> armed_ff)
      else $error("timeout flag set without an armed monitor");

   // The trigger latch never parks in the unused phase
   a_trig_phase: assert property (@(posedge clock) disable iff (reset)
      trig_ph_ff != PH_END)
      else $error("trigger phase in unused code");

   // A word taken in the send phase carries the report strobe
   a_report: assert property (@(posedge clock) disable iff (reset)
      accept && rpt_ph_ff == RPT_SEND |=> rsp_tdata[23] && rsp_tvalid)
      else $error("report strobe missing");

   // Recovery to normal clears every source bit
   a_recover_clear: assert property (@(posedge clock) disable iff (reset)
      accept && em_state_ff == EM_RECOVERABLE && ack |=> rsp_tdata[20:5] == '0)
      else $error("source mask not cleared on recovery");

   // Latched host trigger drives the trigger pin active
   a_trig_pin: assert property (@(posedge clock) disable iff (reset)
      accept && trig_lat_in |=> !rsp_tdata[1])
      else $error("trigger pin not driven while latched");

endmodule

// ----- dv/ess_tick_checker.sv -----
`timescale 1ns / 100ps
// Checker for the emergency stop supervisor: predicts each status word and compares it.
module ess_tick_checker
   import ess_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RspDataBits-1:0] rsp_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CfgAddrBits-1:0] csr_addr,
   input  logic [CfgWidth-1:0]    csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            open_count
);

   localparam int unsigned TimerBits = 16;
   typedef logic [TimerBits-1:0] tick_count_t;

   // One sampled tick, laid out as on the request bus.
   typedef struct packed {
      logic [1:0] pad;
      logic       heartbeat;
      logic       trigger_request;
      logic       reset_request;
      logic       tk1_ok;
      logic       st_ok;
      logic       nxp_ok;
      logic [3:0] esi_pins;
      logic       estop_status_ack;
      logic       estop_status_in;
      logic       estop_logic;
      logic       estop_out_ack;
   } tick_in_t;

   // One status word, laid out as on the response bus.
   typedef struct packed {
      logic                report_strobe;
      logic [1:0]          error_mask;
      logic [MaskBits-1:0] source_mask;
      em_state_type        emergency_state;
      logic                status_copy_pin;
      logic                trigger_pin_n;
      logic                reset_pin;
   } status_t;

   // Configuration copy.
   logic [CfgWidth-1:0] pulse_len, beat_limit, hold_len, report_len;

   // Supervisor state mirror.
   em_state_type        em_state;
   logic [MaskBits-1:0] sources;
   logic                timed_out, beat_seen, pulse_on, trig_held;
   tick_count_t         beat_age, pulse_age, trig_age, rpt_age;
   phase_type           pulse_ph, trig_ph;
   report_phase_type    rpt_ph;

   status_t     expected_status_q[$];
   int unsigned fail_total = 0;

   // Counters stop at their top value instead of wrapping.
   function automatic tick_count_t bump(tick_count_t v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Advances the mirror by one tick and returns the status word it should produce.
   function automatic status_t predict_status(tick_in_t t);
      status_t s;
      logic    recoverable;
      s = '0;

      // Reset pulse: a request restarts the pulse from the next tick.
      case (pulse_ph)
         PH_START: begin
            pulse_age = '0;
            pulse_on  = 1'b1;
            pulse_ph  = PH_COUNT;
         end
         PH_COUNT: begin
            pulse_age = bump(pulse_age);
            if (pulse_age >= pulse_len) pulse_ph = PH_END;
         end
         PH_END: begin
            pulse_on = 1'b0;
            pulse_ph = PH_IDLE;
         end
         default: ;
      endcase
      if (t.reset_request) pulse_ph = PH_START;

      // Heartbeat monitor only judges once the first heartbeat has come.
      if (t.heartbeat) begin
         beat_seen = 1'b1;
         beat_age  = '0;
      end else if (beat_seen) begin
         beat_age = bump(beat_age);
      end
      if (beat_seen) timed_out = (beat_age > beat_limit);

      // Host trigger latch; a request on the expiry tick is swallowed.
      if (t.trigger_request) trig_held = 1'b1;
      case (trig_ph)
         PH_START: begin
            trig_age = '0;
            trig_ph  = PH_COUNT;
         end
         PH_COUNT: begin
            trig_age = bump(trig_age);
            if (trig_age >= hold_len) begin
               trig_held = 1'b0;
               trig_ph   = PH_IDLE;
            end
         end
         default: trig_ph = PH_IDLE;
      endcase
      if (trig_ph == PH_IDLE && trig_held) trig_ph = PH_START;

      recoverable = t.tk1_ok & t.nxp_ok & t.st_ok & t.esi_pins[3];

      // Sticky source bits.
      case (t.esi_pins)
         ESI_PAT_BIT9: sources[SRC_ESI_A] = 1'b1;
         ESI_PAT_BIT0: sources[SRC_ESI_B] = 1'b1;
         ESI_PAT_BIT4: sources[SRC_ESI_C] = 1'b1;
         ESI_PAT_BIT8: sources[SRC_ESI_D] = 1'b1;
         default: ;
      endcase
      if (!t.estop_logic) sources[SRC_LOGIC] = 1'b1;
      if (!t.nxp_ok) sources[SRC_NXP] = 1'b1;
      if (!t.st_ok) sources[SRC_ST] = 1'b1;
      if (!t.tk1_ok) sources[SRC_TK1] = 1'b1;
      if (trig_held) sources[SRC_TRIGGER] = 1'b1;
      if (timed_out) sources[SRC_TIMEOUT] = 1'b1;

      // Emergency state machine; going back to normal wipes the sources.
      case (em_state)
         EM_UNKNOWN: em_state = t.estop_out_ack ? EM_NORMAL : EM_TRIGGERED;
         EM_NORMAL: if (!t.estop_out_ack) em_state = EM_TRIGGERED;
         EM_TRIGGERED: if (recoverable) em_state = EM_RECOVERABLE;
         default: begin
            if (t.estop_out_ack) begin
               sources  = '0;
               em_state = EM_NORMAL;
            end else if (!recoverable) begin
               em_state = EM_TRIGGERED;
            end
         end
      endcase

      // Periodic report strobe.
      case (rpt_ph)
         RPT_COUNT: begin
            rpt_age = bump(rpt_age);
            if (rpt_age >= report_len) rpt_ph = RPT_SEND;
         end
         RPT_SEND: begin
            s.report_strobe = 1'b1;
            rpt_ph          = RPT_START;
         end
         default: begin
            rpt_age = '0;
            rpt_ph  = RPT_COUNT;
         end
      endcase

      s.reset_pin       = pulse_on;
      s.trigger_pin_n   = !(timed_out || trig_held);
      s.status_copy_pin = t.estop_out_ack;
      s.emergency_state = em_state;
      s.source_mask     = sources;
      s.error_mask      = {t.estop_status_in != t.estop_status_ack,
                           t.estop_logic != t.estop_out_ack};
      return s;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         fail_total++;
      end
   endtask

   // Compare finished words first, then take in configuration and new ticks.
   always @(posedge clock) begin : monitor
      status_t got, want;
      if (reset) begin
         pulse_len  = RESET_PULSE_DEF;
         beat_limit = HB_TIMEOUT_DEF;
         hold_len   = TRIGGER_HOLD_DEF;
         report_len = REPORT_PERIOD_DEF;
         em_state   = EM_UNKNOWN;
         sources    = '0;
         timed_out  = 1'b0;
         beat_seen  = 1'b0;
         beat_age   = '0;
         pulse_ph   = PH_IDLE;
         pulse_age  = '0;
         pulse_on   = 1'b0;
         trig_held  = 1'b0;
         trig_ph    = PH_IDLE;
         trig_age   = '0;
         rpt_ph     = RPT_START;
         rpt_age    = '0;
         expected_status_q.delete();
         open_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = status_t'(rsp_tdata);
            if (expected_status_q.size() == 0) begin
               $display("%0t: status word %0h arrived with none expected", $time, rsp_tdata);
               fail_total++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("reset_pin", 32'(want.reset_pin), 32'(got.reset_pin));
               check_field("trigger_pin_n", 32'(want.trigger_pin_n),
                           32'(got.trigger_pin_n));
               check_field("status_copy_pin", 32'(want.status_copy_pin),
                           32'(got.status_copy_pin));
               check_field("emergency_state", 32'(want.emergency_state),
                           32'(got.emergency_state));
               check_field("source_mask", 32'(want.source_mask), 32'(got.source_mask));
               check_field("error_mask", 32'(want.error_mask), 32'(got.error_mask));
               check_field("report_strobe", 32'(want.report_strobe),
                           32'(got.report_strobe));
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_RESET_PULSE:   pulse_len  = csr_wdata;
               REG_HB_TIMEOUT:    beat_limit = csr_wdata;
               REG_TRIGGER_HOLD:  hold_len   = csr_wdata;
               REG_REPORT_PERIOD: report_len = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_status_q.push_back(predict_status(tick_in_t'(req_tdata)));
         end
         open_count <= expected_status_q.size();
      end
      mismatch_count <= fail_total;
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the emergency stop supervisor testbench: clock, reset, stimulus and verdict.
module tb_top
   import ess_pkg::*;
;

   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned LongItems  = 60;

   // Bit positions of the request word.
   localparam int unsigned P_ACK   = 0;
   localparam int unsigned P_LOGIC = 1;
   localparam int unsigned P_STIN  = 2;
   localparam int unsigned P_STACK = 3;
   localparam int unsigned P_ESI   = 4;
   localparam int unsigned P_NXP   = 8;
   localparam int unsigned P_ST    = 9;
   localparam int unsigned P_TK1   = 10;
   localparam int unsigned P_RST   = 11;
   localparam int unsigned P_TRIG  = 12;
   localparam int unsigned P_HB    = 13;

   localparam logic [ReqDataBits-1:0] ACK_BIT  = 16'd1 << P_ACK;
   localparam logic [ReqDataBits-1:0] LOGIC_BIT = 16'd1 << P_LOGIC;
   localparam logic [ReqDataBits-1:0] STIN_BIT = 16'd1 << P_STIN;
   localparam logic [ReqDataBits-1:0] STACK_BIT = 16'd1 << P_STACK;
   localparam logic [ReqDataBits-1:0] NXP_BIT  = 16'd1 << P_NXP;
   localparam logic [ReqDataBits-1:0] TK1_BIT  = 16'd1 << P_TK1;
   localparam logic [ReqDataBits-1:0] RST_BIT  = 16'd1 << P_RST;
   localparam logic [ReqDataBits-1:0] TRIG_BIT = 16'd1 << P_TRIG;
   localparam logic [ReqDataBits-1:0] HB_BIT   = 16'd1 << P_HB;
   localparam logic [ReqDataBits-1:0] EVENT_BITS = RST_BIT | TRIG_BIT | HB_BIT;
   // Healthy tick: acknowledged, no source asserted, no event.
   localparam logic [ReqDataBits-1:0] QUIET = ACK_BIT | LOGIC_BIT | (16'hF << P_ESI) |
                                              NXP_BIT | (16'd1 << P_ST) | TK1_BIT;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we = 1'b0;
   logic [CfgAddrBits-1:0] csr_addr = REG_RESET_PULSE;
   logic [CfgWidth-1:0]    csr_wdata = '0;

   int unsigned mismatch_count, open_count;
   int unsigned cycle_count = 0;
   int unsigned gap_max = 14;
   int unsigned hb_odds = 10;
   logic        ack_level = 1'b1;

   emergency_stop_supervisor_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ess_tick_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [ReqDataBits-1:0] set_esi(input logic [ReqDataBits-1:0] w,
                                                     input logic [3:0] pattern);
      w[P_ESI +: 4] = pattern;
      return w;
   endfunction

   // Mostly plausible ticks with a slowly moving ack level; some pure noise.
   function automatic logic [ReqDataBits-1:0] random_tick();
      logic [ReqDataBits-1:0] w;
      if ($urandom_range(0, 9) == 0) return {2'b00, 14'($urandom)};
      if ($urandom_range(0, 9) == 0) ack_level = ~ack_level;
      w = '0;
      w[P_ACK]   = ack_level;
      w[P_LOGIC] = ($urandom_range(0, 7) == 0) ? ~ack_level : ack_level;
      w[P_STIN]  = 1'($urandom);
      w[P_STACK] = ($urandom_range(0, 3) == 0) ? ~w[P_STIN] : w[P_STIN];
      if ($urandom_range(0, 3) != 0) begin
         // Recoverable pin set with a random lower ESI pattern.
         w[P_ESI +: 4] = {1'b1, 3'($urandom)};
         w[P_NXP]      = 1'b1;
         w[P_ST]       = 1'b1;
         w[P_TK1]      = 1'b1;
      end else begin
         w[P_ESI +: 4] = 4'($urandom);
         w[P_NXP]      = 1'($urandom);
         w[P_ST]       = 1'($urandom);
         w[P_TK1]      = 1'($urandom);
      end
      w[P_RST]  = ($urandom_range(0, 15) == 0);
      w[P_TRIG] = ($urandom_range(0, 24) == 0);
      w[P_HB]   = ($urandom_range(0, hb_odds) == 0);
      return w;
   endfunction

   // Offer one word after a random gap and hold it until it is taken.
   task automatic send_tick(input logic [ReqDataBits-1:0] w);
      int unsigned gap;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   // Wait until every expected status word has come back.
   task automatic wait_idle();
      do @(posedge clock); while (open_count != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input logic [CfgWidth-1:0] pulse, beat, hold, period);
      csr_we    <= 1'b1;
      csr_addr  <= REG_RESET_PULSE;
      csr_wdata <= pulse;
      @(posedge clock);
      csr_addr  <= REG_HB_TIMEOUT;
      csr_wdata <= beat;
      @(posedge clock);
      csr_addr  <= REG_TRIGGER_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_addr  <= REG_REPORT_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [CfgWidth-1:0] pulse, beat, hold, period,
                            input int unsigned n_items, idle_max, beat_odds);
      wait_idle();
      program_regs(pulse, beat, hold, period);
      gap_max = idle_max;
      hb_odds = beat_odds;
      repeat (n_items) send_tick(random_tick());
      req_tvalid <= 1'b0;
   endtask

   // Response side: random stall before each word.
   initial begin : rsp_sink
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      logic [ReqDataBits-1:0] directed_q[$];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks with short timers so every special case shows up quickly.
      directed_q.push_back(16'h0000);
      directed_q.push_back(set_esi(QUIET, ESI_PAT_BIT9));
      directed_q.push_back(set_esi(QUIET, ESI_PAT_BIT0));
      directed_q.push_back(set_esi(QUIET, ESI_PAT_BIT4));
      directed_q.push_back(QUIET);
      directed_q.push_back(16'h3FFF);
      directed_q.push_back(QUIET | RST_BIT);
      directed_q.push_back(QUIET);
      // A second request while the pulse is running restarts it.
      directed_q.push_back(QUIET | RST_BIT);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET);
      // A trigger request that lands on the expiry tick is lost.
      directed_q.push_back(QUIET | TRIG_BIT);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET | TRIG_BIT);
      directed_q.push_back(QUIET | HB_BIT);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET);
      directed_q.push_back(QUIET);
      directed_q.push_back(set_esi(QUIET, ESI_PAT_BIT8));
      // Normal to triggered, recoverable, and back to triggered.
      directed_q.push_back(QUIET & ~ACK_BIT & ~LOGIC_BIT);
      directed_q.push_back((QUIET & ~ACK_BIT & ~NXP_BIT) | STIN_BIT);
      directed_q.push_back(QUIET & ~ACK_BIT);
      directed_q.push_back((QUIET & ~ACK_BIT & ~TK1_BIT) | STACK_BIT);

      program_regs(16'd2, 16'd2, 16'd2, 16'd0);
      foreach (directed_q[i]) send_tick(directed_q[i]);
      req_tvalid <= 1'b0;

      // Random phases over a range of timer settings.
      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 200, 14, 3);
      run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
                16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)), 200, 14, 19);
      run_phase(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 150, 0, 5);
      run_phase(16'($urandom_range(20, 60)), 16'($urandom_range(20, 60)),
                16'($urandom_range(20, 60)), 16'($urandom_range(20, 60)), 200, 14, 40);
      run_phase(RESET_PULSE_DEF, HB_TIMEOUT_DEF, TRIGGER_HOLD_DEF, REPORT_PERIOD_DEF,
                250, 14, 30);

      // Full-scale timers, back to back, with no further events after the first word.
      wait_idle();
      program_regs(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF);
      gap_max = 0;
      send_tick(QUIET | EVENT_BITS);
      repeat (LongItems) send_tick(random_tick() & ~EVENT_BITS);
      req_tvalid <= 1'b0;

      wait_idle();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/ess_pkg.sv
rtl/core/emergency_stop_supervisor_core.sv
dv/ess_tick_checker.sv
dv/tb_top.sv
